[src/mrsa_pkg.sv]
// Shared types, constants and decode functions for the ModR/M/SIB address decoder.
package mrsa_pkg;

  localparam int unsigned RegW     = 32;
  localparam int unsigned NumRegs  = 8;
  localparam int unsigned RegSelW  = 3;

  localparam logic [2:0] R_ESP   = 3'd4;
  localparam logic [2:0] R_EBP   = 3'd5;
  localparam logic [1:0] MOD_MEM0 = 2'd0;
  localparam logic [1:0] MOD_MEM1 = 2'd1;
  localparam logic [1:0] MOD_REG  = 2'd3;

  localparam logic CMD_REG_WRITE = 1'b0;
  localparam logic CMD_CODE_BYTE = 1'b1;

  // Operand descriptor before the address add
  typedef struct packed {
    logic               is_reg;
    logic [2:0]         reg_field;
    logic [2:0]         rm;
    logic [2:0]         base;
    logic [2:0]         index;
    logic               has_base;
    logic               has_index;
    logic [1:0]         ss;
    logic [RegW-1:0]    disp;
    logic [2:0]         bytes_used;
  } desc_t;

  typedef struct packed {
    logic               en;
    logic [RegSelW-1:0] sel;
    logic [RegW-1:0]    value;
  } wr_req_t;

  typedef struct packed {
    logic               en;
    logic [RegSelW-1:0] base;
    logic [RegSelW-1:0] index;
  } rd_req_t;

  // Displacement length in bytes for a given mod and base
  function automatic logic [2:0] disp_bytes_for(input logic [1:0] md, input logic [2:0] base);
    logic [2:0] sz;
    if (md == MOD_MEM0) sz = (base == R_EBP) ? 3'd4 : 3'd0;
    else if (md == MOD_MEM1) sz = 3'd1;
    else sz = 3'd4;
    return sz;
  endfunction

  // Memory operand descriptor from ModR/M, SIB and the gathered displacement bytes
  function automatic desc_t mem_desc(input logic [7:0] modrm, input logic [7:0] sib,
                                     input logic [RegW-1:0] acc);
    desc_t      d;
    logic       sib_used;
    logic [2:0] base;
    logic [2:0] index;
    logic [2:0] dsz;
    logic       hb;
    logic       hi;
    sib_used = (modrm[2:0] == R_ESP);
    base     = sib_used ? sib[2:0] : modrm[2:0];
    index    = sib[5:3];
    dsz      = disp_bytes_for(modrm[7:6], base);
    hb       = !(modrm[7:6] == MOD_MEM0 && base == R_EBP);
    hi       = sib_used && (index != R_ESP);
    d            = '0;
    d.reg_field  = modrm[5:3];
    d.base       = hb ? base : 3'd0;
    d.index      = hi ? index : 3'd0;
    d.has_base   = hb;
    d.has_index  = hi;
    d.ss         = hi ? sib[7:6] : 2'd0;
    if (dsz == 3'd0) d.disp = '0;
    else if (dsz == 3'd1) d.disp = {{(RegW-8){acc[7]}}, acc[7:0]};
    else d.disp = acc;
    d.bytes_used = 3'd1 + {2'b00, sib_used} + dsz;
    return d;
  endfunction

endpackage

[src/mrsa_if.sv]
// Request and result channel interfaces of the address decoder.
interface mrsa_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [2:0]  reg_select;
  logic [31:0] reg_value;
  logic [7:0]  code_byte;

  modport source (output valid, command, reg_select, reg_value, code_byte, input ready);
  modport sink   (input valid, command, reg_select, reg_value, code_byte, output ready);
endinterface

interface mrsa_out_if;
  logic               valid;
  logic               ready;
  logic               operand_is_register;
  logic [2:0]         reg_field;
  logic [2:0]         rm_register;
  logic [2:0]         base_register;
  logic [2:0]         index_register;
  logic               has_base;
  logic               has_index;
  logic [1:0]         scale_shift;
  logic signed [31:0] displacement;
  logic [31:0]        effective_address;
  logic [2:0]         bytes_used;

  modport source (output valid, operand_is_register, reg_field, rm_register, base_register,
                  index_register, has_base, has_index, scale_shift, displacement,
                  effective_address, bytes_used, input ready);
  modport sink   (input valid, operand_is_register, reg_field, rm_register, base_register,
                  index_register, has_base, has_index, scale_shift, displacement,
                  effective_address, bytes_used, output ready);
endinterface

[src/mrsa_ram.sv]
// Generic single-write, registered-read RAM.
module mrsa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
  input  logic [Width-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
  output logic [Width-1:0]                            rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/mrsa_regfile.sv]
// General register file: two read ports (base, index), reset-to-zero via valid bits.
module mrsa_regfile import mrsa_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  wr_req_t         wr,
  input  rd_req_t         rd,
  output logic [RegW-1:0] base_val,
  output logic [RegW-1:0] index_val
);

  logic [NumRegs-1:0] written;
  logic               base_ok;
  logic               index_ok;
  logic [RegW-1:0]    base_raw;
  logic [RegW-1:0]    index_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      written  <= '0;
      base_ok  <= 1'b0;
      index_ok <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.sel] <= 1'b1;
      end
      if (rd.en) begin
        base_ok  <= written[rd.base];
        index_ok <= written[rd.index];
      end
    end
  end

  mrsa_ram #(.Width(RegW), .Depth(NumRegs)) u_base_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.sel),
    .wdata (wr.value),
    .re    (rd.en),
    .raddr (rd.base),
    .rdata (base_raw)
  );

  mrsa_ram #(.Width(RegW), .Depth(NumRegs)) u_index_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.sel),
    .wdata (wr.value),
    .re    (rd.en),
    .raddr (rd.index),
    .rdata (index_raw)
  );

  assign base_val  = base_ok  ? base_raw  : '0;
  assign index_val = index_ok ? index_raw : '0;

endmodule

[src/mrsa_parse.sv]
// Byte-stream parser: ModR/M, SIB and displacement phases, descriptor stage register.
module mrsa_parse import mrsa_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  mrsa_in_if.sink      stream,
  input  logic         take,
  output logic         desc_valid,
  output desc_t        desc,
  output wr_req_t      wr,
  output rd_req_t      rd
);

  localparam logic [1:0] PH_MODRM = 2'd0;
  localparam logic [1:0] PH_SIB   = 2'd1;
  localparam logic [1:0] PH_DISP  = 2'd2;

  logic [1:0]      phase;
  logic [1:0]      phase_next;
  logic [7:0]      held_modrm;
  logic [7:0]      held_modrm_next;
  logic [7:0]      held_sib;
  logic [7:0]      held_sib_next;
  logic [RegW-1:0] acc;
  logic [RegW-1:0] acc_next;
  logic [2:0]      left;
  logic [2:0]      left_next;

  logic            accept;
  logic            emit;
  desc_t           desc_new;
  logic [2:0]      dsz;
  logic [2:0]      size;
  logic [2:0]      left_eff;
  logic [2:0]      left_dec;
  logic [1:0]      pos;
  logic [RegW-1:0] acc_or;
  logic [7:0]      b;

  assign stream.ready = !desc_valid || take;
  assign accept       = stream.valid && stream.ready;
  assign b            = stream.code_byte;

  assign wr.en    = accept && (stream.command == CMD_REG_WRITE);
  assign wr.sel   = stream.reg_select;
  assign wr.value = stream.reg_value;

  always_comb begin
    phase_next      = phase;
    held_modrm_next = held_modrm;
    held_sib_next   = held_sib;
    acc_next        = acc;
    left_next       = left;
    emit            = 1'b0;
    desc_new        = '0;
    dsz             = '0;
    size            = (held_modrm[7:6] == MOD_MEM1) ? 3'd1 : 3'd4;
    left_eff        = (left == 3'd0 || left > size) ? size : left;
    left_dec        = left_eff - 3'd1;
    pos             = 2'(size - left_eff);
    acc_or          = acc | ({{(RegW-8){1'b0}}, b} << {pos, 3'b000});
    if (accept && stream.command == CMD_CODE_BYTE) begin
      unique case (phase)
        PH_SIB: begin
          held_sib_next = b;
          dsz           = disp_bytes_for(held_modrm[7:6], b[2:0]);
          acc_next      = '0;
          if (dsz == 3'd0) begin
            phase_next = PH_MODRM;
            left_next  = '0;
            emit       = 1'b1;
            desc_new   = mem_desc(held_modrm, b, '0);
          end else begin
            phase_next = PH_DISP;
            left_next  = dsz;
          end
        end
        PH_DISP: begin
          acc_next  = acc_or;
          left_next = left_dec;
          if (left_dec == 3'd0) begin
            phase_next = PH_MODRM;
            emit       = 1'b1;
            desc_new   = mem_desc(held_modrm, held_sib, acc_or);
          end
        end
        default: begin
          // ModR/M byte; an unused phase code is treated the same way
          held_modrm_next = b;
          held_sib_next   = '0;
          if (b[7:6] == MOD_REG) begin
            phase_next         = PH_MODRM;
            left_next          = '0;
            acc_next           = '0;
            emit               = 1'b1;
            desc_new.is_reg    = 1'b1;
            desc_new.reg_field = b[5:3];
            desc_new.rm        = b[2:0];
            desc_new.bytes_used = 3'd1;
          end else if (b[2:0] == R_ESP) begin
            phase_next = PH_SIB;
          end else begin
            dsz      = disp_bytes_for(b[7:6], b[2:0]);
            acc_next = '0;
            if (dsz == 3'd0) begin
              phase_next = PH_MODRM;
              left_next  = '0;
              emit       = 1'b1;
              desc_new   = mem_desc(b, 8'h00, '0);
            end else begin
              phase_next = PH_DISP;
              left_next  = dsz;
            end
          end
        end
      endcase
    end
  end

  // Register file read issued alongside the descriptor load
  assign rd.en    = emit;
  assign rd.base  = desc_new.base;
  assign rd.index = desc_new.index;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_MODRM;
      held_modrm <= '0;
      held_sib   <= '0;
      acc        <= '0;
      left       <= '0;
      desc_valid <= 1'b0;
    end else begin
      phase      <= phase_next;
      held_modrm <= held_modrm_next;
      held_sib   <= held_sib_next;
      acc        <= acc_next;
      left       <= left_next;
      if (emit) begin
        desc_valid <= 1'b1;
      end else if (take) begin
        desc_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      desc <= desc_new;
    end
  end

endmodule

[src/mrsa_ea.sv]
// Effective address adder and result register.
module mrsa_ea import mrsa_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            desc_valid,
  input  desc_t           desc,
  input  logic [RegW-1:0] base_val,
  input  logic [RegW-1:0] index_val,
  output logic            take,
  mrsa_out_if.source      result
);

  logic [RegW-1:0] scaled;
  logic [RegW-1:0] ea;

  assign scaled = index_val << desc.ss;
  assign ea     = desc.disp
                + (desc.has_base  ? base_val : '0)
                + (desc.has_index ? scaled   : '0);
  assign take   = desc_valid && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.operand_is_register <= desc.is_reg;
      result.reg_field           <= desc.reg_field;
      result.rm_register         <= desc.rm;
      result.base_register       <= desc.base;
      result.index_register      <= desc.index;
      result.has_base            <= desc.has_base;
      result.has_index           <= desc.has_index;
      result.scale_shift         <= desc.ss;
      result.displacement        <= $signed(desc.disp);
      result.effective_address   <= ea;
      result.bytes_used          <= desc.bytes_used;
    end
  end

endmodule

[src/modrm_sib_address_decoder.sv]
// Top level of the 32-bit x86 ModR/M/SIB operand and effective address decoder.
// One request is taken per cycle: either a write to one of the eight general
// registers or the next instruction byte. The parser walks ModR/M, optional SIB
// and 0, 1 or 4 displacement bytes; on the final byte of an operand it loads a
// descriptor stage and reads base and index from the register file (two small
// RAMs with registered read, kept in step by every write; entries never written
// read as zero through per-register valid bits, so no clearing pass is needed).
// From the descriptor stage the sum disp + base + (index << ss) goes into the
// result register. Throughput is one request per cycle with no bubbles;
// stalls on the result side hold the descriptor stage and in turn deassert
// ready. Register writes that arrive mid-operand are applied at once and seen
// by the address of that operand.
module modrm_sib_address_decoder import mrsa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mrsa_in_if.sink    stream,
  mrsa_out_if.source result
);

  wr_req_t         wr;
  rd_req_t         rd;
  desc_t           desc;
  logic            desc_valid;
  logic            take;
  logic [RegW-1:0] base_val;
  logic [RegW-1:0] index_val;

  // Phase tracking, displacement gathering and descriptor stage
  mrsa_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .stream     (stream),
    .take       (take),
    .desc_valid (desc_valid),
    .desc       (desc),
    .wr         (wr),
    .rd         (rd)
  );

  // Register file, read data lines up with the descriptor stage
  mrsa_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .rd        (rd),
    .base_val  (base_val),
    .index_val (index_val)
  );

  // Three-input address add into the result register
  mrsa_ea u_ea (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (desc_valid),
    .desc       (desc),
    .base_val   (base_val),
    .index_val  (index_val),
    .take       (take),
    .result     (result)
  );

endmodule

[bench/tb.sv]
// Self-checking bench for the ModR/M/SIB operand and effective address decoder.
module tb;
  import mrsa_pkg::*;

  // Run shape
  localparam int unsigned TotalRequests = 1400;
  localparam int unsigned CalmTail      = 150;  // last requests go with no idling
  localparam int unsigned BacklogAfter  = 400;  // requests taken before the long hold
  localparam int unsigned BacklogCycles = 300;  // result side held off this long
  localparam int unsigned DrainCycles   = 16;   // wait after the last expected result
  localparam int unsigned ReportLimit   = 10;

  // Where the shadow parser stands in the current operand
  typedef enum logic [1:0] {
    WANT_MODRM,
    WANT_SIB,
    WANT_DISP
  } parse_phase_t;

  typedef struct packed {
    logic            command;
    logic [2:0]      reg_select;
    logic [RegW-1:0] reg_value;
    logic [7:0]      code_byte;
  } request_t;

  typedef struct packed {
    logic                   operand_is_register;
    logic [2:0]             reg_field;
    logic [2:0]             rm_register;
    logic [2:0]             base_register;
    logic [2:0]             index_register;
    logic                   has_base;
    logic                   has_index;
    logic [1:0]             scale_shift;
    logic signed [RegW-1:0] displacement;
    logic [RegW-1:0]        effective_address;
    logic [2:0]             bytes_used;
  } operand_t;

  // One line of the directed plan; typed rows carry their operand written out by hand
  typedef struct packed {
    request_t req;
    logic     typed;
    operand_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic quiet = 1'b0;         // no idling on either side once set
  logic backlog_hold = 1'b0;  // long hold-off on the result side

  int unsigned requests_taken = 0;
  int unsigned mismatches = 0;

  // Shadow of the decoder: register file and parse state, at reset values
  logic [RegW-1:0] gpr_shadow [NumRegs] = '{default: '0};
  parse_phase_t    phase = WANT_MODRM;
  logic [7:0]      modrm_byte = '0;
  logic [7:0]      sib_byte = '0;
  logic [RegW-1:0] disp_acc = '0;
  logic [2:0]      disp_left = '0;

  operand_t expected_operands [$];

  mrsa_in_if  req_ch ();
  mrsa_out_if res_ch ();

  modrm_sib_address_decoder DUT (
    .clk    (clk),
    .rst    (rst),
    .stream (req_ch),
    .result (res_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow decoder
  // ---------------------------------------------------------------------------

  // Displacement length: mod 1 one byte, mod 2 four; mod 0 none unless the base
  // is EBP, which then means no base and a 32-bit absolute displacement.
  function automatic logic [2:0] disp_len(input logic [1:0] md, input logic [2:0] base);
    if (md == MOD_MEM0) return (base == R_EBP) ? 3'd4 : 3'd0;
    if (md == MOD_MEM1) return 3'd1;
    return 3'd4;
  endfunction

  function automatic operand_t reg_operand(input logic [2:0] rf, input logic [2:0] rm);
    operand_t op;
    op = '0;
    op.operand_is_register = 1'b1;
    op.reg_field = rf;
    op.rm_register = rm;
    op.bytes_used = 3'd1;
    return op;
  endfunction

  // Memory operand from the held ModR/M, SIB and displacement, using the
  // register file as it stands when the last byte is taken.
  function automatic operand_t memory_operand();
    operand_t        op;
    logic            sib_present;
    logic [2:0]      base;
    logic [2:0]      idx;
    logic [2:0]      n;
    logic [RegW-1:0] d;
    logic [RegW-1:0] ea;
    sib_present = (modrm_byte[2:0] == R_ESP);
    base = sib_present ? sib_byte[2:0] : modrm_byte[2:0];
    idx  = sib_byte[5:3];
    n    = disp_len(modrm_byte[7:6], base);
    op = '0;
    op.reg_field = modrm_byte[5:3];
    op.has_base  = !(modrm_byte[7:6] == MOD_MEM0 && base == R_EBP);
    // index 4 in the SIB byte stands for no index at all
    op.has_index = sib_present && (idx != R_ESP);
    case (n)
      3'd0:    d = '0;
      3'd1:    d = {{(RegW-8){disp_acc[7]}}, disp_acc[7:0]};
      default: d = disp_acc;
    endcase
    ea = d;
    if (op.has_base) begin
      op.base_register = base;
      ea = ea + gpr_shadow[base];
    end
    if (op.has_index) begin
      op.index_register = idx;
      op.scale_shift = sib_byte[7:6];
      ea = ea + (gpr_shadow[idx] << sib_byte[7:6]);
    end
    op.displacement = d;
    op.effective_address = ea;
    op.bytes_used = 3'd1 + {2'b00, sib_present} + n;
    return op;
  endfunction

  // ModR/M (no SIB) or SIB has been taken: finish now or go and collect displacement
  task automatic address_bytes_done(input logic [2:0] base, output logic done,
                                    output operand_t op);
    logic [2:0] n;
    n = disp_len(modrm_byte[7:6], base);
    disp_acc = '0;
    done = 1'b0;
    op = '0;
    if (n == 3'd0) begin
      phase = WANT_MODRM;
      disp_left = '0;
      op = memory_operand();
      done = 1'b1;
    end else begin
      phase = WANT_DISP;
      disp_left = n;
    end
  endtask

  task automatic decode_request(input request_t r, output logic done, output operand_t op);
    logic [2:0] width;
    logic [2:0] slot;
    done = 1'b0;
    op = '0;
    // register writes land at once, even part-way through an operand
    if (r.command == CMD_REG_WRITE) begin
      gpr_shadow[r.reg_select] = r.reg_value;
      return;
    end
    case (phase)
      WANT_SIB: begin
        sib_byte = r.code_byte;
        address_bytes_done(sib_byte[2:0], done, op);
      end
      WANT_DISP: begin
        // little-endian: the first displacement byte is the lowest
        width = (modrm_byte[7:6] == MOD_MEM1) ? 3'd1 : 3'd4;
        if (disp_left == 3'd0 || disp_left > width) disp_left = width;
        slot = width - disp_left;
        disp_acc = disp_acc | ({{(RegW-8){1'b0}}, r.code_byte} << (8 * slot[1:0]));
        disp_left = disp_left - 3'd1;
        if (disp_left == 3'd0) begin
          phase = WANT_MODRM;
          op = memory_operand();
          done = 1'b1;
        end
      end
      default: begin
        modrm_byte = r.code_byte;
        sib_byte = '0;
        if (modrm_byte[7:6] == MOD_REG) begin
          op = reg_operand(modrm_byte[5:3], modrm_byte[2:0]);
          phase = WANT_MODRM;
          disp_left = '0;
          disp_acc = '0;
          done = 1'b1;
        end else if (modrm_byte[2:0] == R_ESP) begin
          phase = WANT_SIB;
        end else begin
          address_bytes_done(modrm_byte[2:0], done, op);
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Code byte; the unused fields carry junk so that every bit toggles
  function automatic request_t code_req(input logic [7:0] b);
    request_t r;
    r.command = CMD_CODE_BYTE;
    r.reg_select = 3'($urandom_range(0, NumRegs - 1));
    r.reg_value = $urandom;
    r.code_byte = b;
    return r;
  endfunction

  function automatic request_t write_req(input logic [2:0] sel, input logic [RegW-1:0] val);
    request_t r;
    r.command = CMD_REG_WRITE;
    r.reg_select = sel;
    r.reg_value = val;
    r.code_byte = 8'($urandom);
    return r;
  endfunction

  function automatic request_t random_write();
    int unsigned pick;
    logic [RegW-1:0] val;
    pick = $urandom_range(0, 9);
    val = (pick == 0) ? '0 : (pick == 1) ? '1 : RegW'($urandom);
    return write_req(3'($urandom_range(0, NumRegs - 1)), val);
  endfunction

  function automatic row_t code(input logic [7:0] b, input logic typed = 1'b0,
                                input operand_t want = '0);
    row_t row;
    row.req = code_req(b);
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic row_t reg_write(input logic [2:0] sel, input logic [RegW-1:0] val);
    row_t row;
    row.req = write_req(sel, val);
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic operand_t mem_operand(input logic [2:0] rf, input logic hb,
                                           input logic [2:0] base, input logic [RegW-1:0] d,
                                           input logic [RegW-1:0] ea, input logic [2:0] n);
    operand_t op;
    op = '0;
    op.reg_field = rf;
    op.has_base = hb;
    op.base_register = base;
    op.displacement = d;
    op.effective_address = ea;
    op.bytes_used = n;
    return op;
  endfunction

  // Offer one request, optionally after a gap, and predict once it is taken.
  // Typed rows stand in for the prediction; the shadow state still advances.
  task automatic offer(input request_t r, input logic typed = 1'b0,
                       input operand_t want = '0);
    logic     done;
    operand_t op;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.command    <= r.command;
    req_ch.reg_select <= r.reg_select;
    req_ch.reg_value  <= r.reg_value;
    req_ch.code_byte  <= r.code_byte;
    do @(posedge clk); while (!req_ch.ready);
    requests_taken++;
    decode_request(r, done, op);
    if (done) expected_operands.push_back(typed ? want : op);
  endtask

  // One operand with random content: ModR/M, SIB when r/m picks one, then the
  // displacement. Register writes are slipped in between bytes now and then,
  // and a few operands are cut short so that the next one runs into them.
  task automatic random_operand();
    logic [7:0]  modrm;
    logic [7:0]  sib;
    logic        sib_present;
    int unsigned n;
    int unsigned cut;
    modrm = 8'($urandom);
    sib = 8'($urandom);
    sib_present = (modrm[7:6] != MOD_REG) && (modrm[2:0] == R_ESP);
    if (modrm[7:6] == MOD_REG) n = 1;
    else n = 1 + sib_present + disp_len(modrm[7:6], sib_present ? sib[2:0] : modrm[2:0]);
    cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, n) : n;
    for (int k = 0; k < cut; k++) begin
      if ($urandom_range(0, 9) == 0) offer(random_write());
      if (k == 0) offer(code_req(modrm));
      else if (k == 1 && sib_present) offer(code_req(sib));
      else offer(code_req(8'($urandom)));
    end
  endtask

  initial begin : request_driver
    row_t plan [$];
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_CODE_BYTE;
    req_ch.reg_select = '0;
    req_ch.reg_value = '0;
    req_ch.code_byte = '0;

    // Directed plan. Register operands and the first memory operands straight
    // after reset read a zero register file, so they are written out here.
    plan = '{
      code(8'hC0, 1'b1, reg_operand(3'd0, 3'd0)),   // register operand, low extreme
      code(8'hFF, 1'b1, reg_operand(3'd7, 3'd7)),   // register operand, high extreme
      code(8'h00, 1'b1, mem_operand(3'd0, 1'b1, 3'd0, '0, '0, 3'd1)),  // [EAX]
      code(8'h2D),                                   // mod 0, r/m EBP: absolute disp32
      code(8'hFF), code(8'hFF), code(8'hFF),
      code(8'hFF, 1'b1, mem_operand(3'd5, 1'b0, 3'd0, '1, '1, 3'd5)),
      reg_write(3'd0, '1),
      reg_write(3'd5, 32'h0000_1000),
      code(8'h44),                                   // mod 1 with SIB
      code(8'hE0),                                   // index 4: no index, scale ignored
      code(8'h80),                                   // disp8 of -128, wraps below EAX
      code(8'hBC),                                   // mod 2 with SIB, reg field 7
      code(8'hF5),                                   // EBP base + ESI << 3
      code(8'h78), code(8'h56),
      reg_write(3'd6, 32'h0000_0003),                // index written mid-operand
      code(8'h34), code(8'h12),
      code(8'h04),                                   // mod 0 with SIB
      code(8'h25),                                   // no base, no index: disp32 only
      code(8'hEF), code(8'hBE), code(8'hAD), code(8'hDE)
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) offer(plan[i].req, plan[i].typed, plan[i].want);

    // Random part: mostly whole operands, some lone register writes
    while (requests_taken < TotalRequests) begin
      if (requests_taken >= TotalRequests - CalmTail) quiet <= 1'b1;
      if ($urandom_range(0, 6) == 0) offer(random_write());
      else random_operand();
    end
    req_ch.valid <= 1'b0;

    while (expected_operands.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && expected_operands.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Long hold-off on the result side while requests keep coming, so that the
  // descriptor stage fills and the decoder has to drop its ready.
  initial begin : backlog
    wait (requests_taken >= BacklogAfter);
    @(posedge clk);
    backlog_hold <= 1'b1;
    repeat (BacklogCycles) @(posedge clk);
    backlog_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  function automatic string describe(input operand_t o);
    return $sformatf({"reg=%0d rf=%0d rm=%0d base=%0d/%0d index=%0d/%0d ss=%0d ",
                      "disp=%h ea=%h bytes=%0d"},
                     o.operand_is_register, o.reg_field, o.rm_register, o.has_base,
                     o.base_register, o.has_index, o.index_register, o.scale_shift,
                     o.displacement, o.effective_address, o.bytes_used);
  endfunction

  task automatic check_operand(input operand_t got);
    operand_t want;
    if (expected_operands.size() == 0) begin
      mismatches++;
      if (mismatches <= ReportLimit) $display("unexpected result: %s", describe(got));
      return;
    end
    want = expected_operands.pop_front();
    // the packed compare covers every field at its own width
    if (got !== want) begin
      mismatches++;
      if (mismatches <= ReportLimit) begin
        $display("operand mismatch");
        $display("  expected %s", describe(want));
        $display("  actual   %s", describe(got));
      end
    end
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    operand_t    got;
    stall_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (res_ch.valid && res_ch.ready) begin
          got.operand_is_register = res_ch.operand_is_register;
          got.reg_field           = res_ch.reg_field;
          got.rm_register         = res_ch.rm_register;
          got.base_register       = res_ch.base_register;
          got.index_register      = res_ch.index_register;
          got.has_base            = res_ch.has_base;
          got.has_index           = res_ch.has_index;
          got.scale_shift         = res_ch.scale_shift;
          got.displacement        = res_ch.displacement;
          got.effective_address   = res_ch.effective_address;
          got.bytes_used          = res_ch.bytes_used;
          check_operand(got);
        end
        // random stalls come in bursts, none in the calm tail
        if (backlog_hold) begin
          res_ch.ready <= 1'b0;
        end else if (stall_left != 0) begin
          stall_left--;
          res_ch.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
          stall_left = $urandom_range(0, 17);
          res_ch.ready <= 1'b0;
        end else begin
          res_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Hard limit, far beyond the slowest correct run
  initial begin : watchdog
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
